[src/json_string_unescape_unit_macros.svh]
// Assertion macros shared by the string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/jsu_pkg.sv]
// Types, codes and helper functions of the string unescape unit.
package jsu_pkg;

	// input beat: end-of-text flag and one raw text byte
	typedef struct packed {
		logic       cmd;
		logic [7:0] in_byte;
	} in_beat_t;

	// result beat: one decoded byte, a done mark or an error code
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       done_res;
		logic [3:0] error_code;
		logic       last;
	} out_beat_t;

	// scan phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_ESC,
		PH_HEX1,
		PH_WANT_BS,
		PH_WANT_U,
		PH_HEX2
	} phase_t;

	// error codes
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
	localparam logic [3:0] ERR_CONTROL     = 4'd2;
	localparam logic [3:0] ERR_UNTERM      = 4'd3;
	localparam logic [3:0] ERR_BAD_HEX     = 4'd4;
	localparam logic [3:0] ERR_BAD_LOW_HEX = 4'd5;
	localparam logic [3:0] ERR_NOT_LOW     = 4'd6;
	localparam logic [3:0] ERR_MISSING_U   = 4'd7;
	localparam logic [3:0] ERR_LOW_OR_ESC  = 4'd8;

	// characters
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5c;
	localparam logic [7:0] CH_SLASH    = 8'h2f;
	localparam logic [7:0] CH_B        = 8'h62;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_N        = 8'h6e;
	localparam logic [7:0] CH_R        = 8'h72;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_U        = 8'h75;
	localparam logic [7:0] CTRL_MAX    = 8'h1f;

	// surrogate ranges
	localparam logic [15:0] HIGH_FIRST = 16'hd800;
	localparam logic [15:0] HIGH_LAST  = 16'hdbff;
	localparam logic [15:0] LOW_FIRST  = 16'hdc00;
	localparam logic [15:0] LOW_LAST   = 16'hdfff;
	localparam logic [20:0] PLANE1     = 21'h10000;

	localparam logic [4:0] HEX_NONE    = 5'd16;

	// all result beats caused by one input beat; count 0 means none
	typedef struct packed {
		logic [2:0]      count;
		logic            is_data;
		logic            done;
		logic [3:0]      err;
		logic [3:0][7:0] bytes;
	} grp_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} utf8_t;

	// value of a hex digit, HEX_NONE for any other byte
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = 5'(c[3:0] + 4'd9);
		end
		return r;
	endfunction

	// encode one code point as UTF-8, first byte in bytes[0]
	function automatic utf8_t utf8_encode(input logic [20:0] code);
		utf8_t r;
		r.bytes = '0;
		if (code <= 21'h7f) begin
			r.len = 3'd1;
			r.bytes[0] = {1'b0, code[6:0]};
		end else if (code <= 21'h7ff) begin
			r.len = 3'd2;
			r.bytes[0] = {3'b110, code[10:6]};
			r.bytes[1] = {2'b10, code[5:0]};
		end else if (code <= 21'hffff) begin
			r.len = 3'd3;
			r.bytes[0] = {4'b1110, code[15:12]};
			r.bytes[1] = {2'b10, code[11:6]};
			r.bytes[2] = {2'b10, code[5:0]};
		end else begin
			r.len = 3'd4;
			r.bytes[0] = {5'b11110, code[20:18]};
			r.bytes[1] = {2'b10, code[17:12]};
			r.bytes[2] = {2'b10, code[11:6]};
			r.bytes[3] = {2'b10, code[5:0]};
		end
		return r;
	endfunction

endpackage

[src/jsu_decode.sv]
// Scan state and decode of one text beat into a group of result beats.
module jsu_decode import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_beat_t beat,
	output grp_t     grp
);

	phase_t      phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  high_q, high_d;

	logic [7:0]  c;
	logic        is_ctrl;
	logic [4:0]  dig;
	logic        is_hex;
	logic [15:0] hex_next;
	logic        grp_full;
	logic        in_high;
	logic        in_low;
	logic [20:0] pair_code;
	utf8_t       enc_single;
	utf8_t       enc_pair;

	// shared decode terms
	assign c          = beat.in_byte;
	assign is_ctrl    = (c <= CTRL_MAX);
	assign dig        = hex_digit(c);
	assign is_hex     = (dig != HEX_NONE);
	assign hex_next   = {hex_q[11:0], dig[3:0]};
	assign grp_full   = (cnt_q == 2'd3);
	assign in_high    = (hex_next >= HIGH_FIRST) && (hex_next <= HIGH_LAST);
	assign in_low     = (hex_next >= LOW_FIRST) && (hex_next <= LOW_LAST);
	assign pair_code  = 21'({high_q, hex_next[9:0]}) + PLANE1;
	assign enc_single = utf8_encode({5'd0, hex_next});
	assign enc_pair   = utf8_encode(pair_code);

	// next state
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		cnt_d   = cnt_q;
		high_d  = high_q;
		if (beat.cmd) begin
			phase_d = PH_IDLE;
			hex_d   = '0;
			cnt_d   = '0;
			high_d  = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (c == CH_QUOTE) phase_d = PH_BODY;
				end
				PH_BODY: begin
					if (c == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else if (c == CH_QUOTE || is_ctrl) begin
						phase_d = PH_IDLE;
						hex_d   = '0;
						cnt_d   = '0;
						high_d  = '0;
					end
				end
				PH_ESC: begin
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
							phase_d = PH_BODY;
						end
						CH_U: begin
							phase_d = PH_HEX1;
							hex_d   = '0;
							cnt_d   = '0;
						end
						default: begin
							phase_d = PH_IDLE;
							hex_d   = '0;
							cnt_d   = '0;
							high_d  = '0;
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (is_ctrl || !is_hex) begin
						phase_d = PH_IDLE;
						hex_d   = '0;
						cnt_d   = '0;
						high_d  = '0;
					end else begin
						hex_d = hex_next;
						cnt_d = 2'(cnt_q + 2'd1);
						if (grp_full) begin
							if (phase_q == PH_HEX1 && in_high) begin
								high_d  = hex_next[9:0];
								phase_d = PH_WANT_BS;
							end else if ((phase_q == PH_HEX1 && in_low) ||
									(phase_q == PH_HEX2 && !in_low)) begin
								phase_d = PH_IDLE;
								hex_d   = '0;
								cnt_d   = '0;
								high_d  = '0;
							end else begin
								phase_d = PH_BODY;
								if (phase_q == PH_HEX2) high_d = '0;
							end
						end
					end
				end
				PH_WANT_BS: begin
					if (c == CH_BSLASH) begin
						phase_d = PH_WANT_U;
					end else begin
						phase_d = PH_IDLE;
						hex_d   = '0;
						cnt_d   = '0;
						high_d  = '0;
					end
				end
				PH_WANT_U: begin
					if (c == CH_U) begin
						phase_d = PH_HEX2;
						hex_d   = '0;
						cnt_d   = '0;
					end else begin
						phase_d = PH_IDLE;
						hex_d   = '0;
						cnt_d   = '0;
						high_d  = '0;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					hex_d   = '0;
					cnt_d   = '0;
					high_d  = '0;
				end
			endcase
		end
	end

	// result group
	always_comb begin
		grp = '0;
		if (beat.cmd) begin
			grp.count = 3'd1;
			grp.err   = (phase_q == PH_IDLE) ? ERR_NO_QUOTE : ERR_UNTERM;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (c != CH_QUOTE) begin
						grp.count = 3'd1;
						grp.err   = ERR_NO_QUOTE;
					end
				end
				PH_BODY: begin
					if (c == CH_QUOTE) begin
						grp.count = 3'd1;
						grp.done  = 1'b1;
					end else if (is_ctrl) begin
						grp.count = 3'd1;
						grp.err   = ERR_CONTROL;
					end else if (c != CH_BSLASH) begin
						grp.count    = 3'd1;
						grp.is_data  = 1'b1;
						grp.bytes[0] = c;
					end
				end
				PH_ESC: begin
					grp.count   = 3'd1;
					grp.is_data = 1'b1;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: grp.bytes[0] = c;
						CH_B: grp.bytes[0] = 8'h08;
						CH_F: grp.bytes[0] = 8'h0c;
						CH_N: grp.bytes[0] = 8'h0a;
						CH_R: grp.bytes[0] = 8'h0d;
						CH_T: grp.bytes[0] = 8'h09;
						CH_U: begin
							grp.count   = 3'd0;
							grp.is_data = 1'b0;
						end
						default: begin
							grp.is_data = 1'b0;
							grp.err     = ERR_LOW_OR_ESC;
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (is_ctrl) begin
						grp.count = 3'd1;
						grp.err   = ERR_CONTROL;
					end else if (!is_hex) begin
						grp.count = 3'd1;
						grp.err   = (phase_q == PH_HEX1) ? ERR_BAD_HEX : ERR_BAD_LOW_HEX;
					end else if (grp_full) begin
						if (phase_q == PH_HEX1) begin
							if (in_low) begin
								grp.count = 3'd1;
								grp.err   = ERR_LOW_OR_ESC;
							end else if (!in_high) begin
								grp.count   = enc_single.len;
								grp.is_data = 1'b1;
								grp.bytes   = enc_single.bytes;
							end
						end else if (!in_low) begin
							grp.count = 3'd1;
							grp.err   = ERR_NOT_LOW;
						end else begin
							grp.count   = enc_pair.len;
							grp.is_data = 1'b1;
							grp.bytes   = enc_pair.bytes;
						end
					end
				end
				PH_WANT_BS: begin
					if (c != CH_BSLASH) begin
						grp.count = 3'd1;
						grp.err   = is_ctrl ? ERR_CONTROL : ERR_MISSING_U;
					end
				end
				PH_WANT_U: begin
					if (c != CH_U) begin
						grp.count = 3'd1;
						grp.err   = ERR_MISSING_U;
					end
				end
				default: begin
					grp.count = 3'd1;
					grp.err   = ERR_NO_QUOTE;
				end
			endcase
		end
	end

	// advance scan state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= '0;
			cnt_q   <= '0;
			high_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			cnt_q   <= cnt_d;
			high_q  <= high_d;
		end
	end

endmodule

[src/json_string_unescape_unit.sv]
// Top level of the JSON string unescape unit: decode, group queue, result register.
//
//  channel | beat type  | valid     | stall     | payload
//  --------+------------+-----------+-----------+----------
//  input   | in_beat_t  | src_valid | src_stall | src_beat
//  result  | out_beat_t | res_valid | res_stall | res_beat
//
// One text beat is decoded in the cycle it is accepted; a non-empty result group
// enters a two-slot group queue and leaves through the result register one beat a
// cycle while the result side is not stalled. A beat can be accepted every cycle
// until both queue slots are occupied: a stalled result side or a multi-byte UTF-8
// group (2 to 4 beats) does so. Reset clears the scan state, the queue and the result
// register; no clearing pass is needed.
module json_string_unescape_unit import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_beat_t  src_beat,
	output logic      res_valid,
	input  logic      res_stall,
	output out_beat_t res_beat
);

	`include "json_string_unescape_unit_macros.svh"

	grp_t       grp;
	grp_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	out_beat_t  out_q;

	logic       src_fire;
	logic       push;
	logic       load;
	logic       pop;
	grp_t       head;
	logic       head_last;
	out_beat_t  next_beat;

	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (src_fire),
		.beat   (src_beat),
		.grp    (grp)
	);

	// handshake and queue control
	assign src_stall = (fill_q == 2'd2);
	assign src_fire  = src_valid && !src_stall;
	assign push      = src_fire && (grp.count != 3'd0);
	assign head      = slot_q[rd_ptr_q];
	assign head_last = ({1'b0, idx_q} == 3'(head.count - 3'd1));
	assign load      = (fill_q != 2'd0) && (!out_valid_q || !res_stall);
	assign pop       = load && head_last;

	// build the next result beat from the head group
	always_comb begin
		next_beat            = '0;
		next_beat.out_valid  = head.is_data;
		next_beat.out_byte   = head.is_data ? head.bytes[idx_q] : 8'h00;
		next_beat.done_res   = head.done;
		next_beat.error_code = head.err;
		next_beat.last       = head_last;
	end

	// store groups
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= grp;
	end

	// advance queue pointers and item index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) fill_q <= 2'(fill_q + 2'd1);
			else if (pop && !push) fill_q <= 2'(fill_q - 2'd1);
			if (pop) idx_q <= 2'd0;
			else if (load) idx_q <= 2'(idx_q + 2'd1);
		end
	end

	// hold or refill the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= next_beat;
	end

	assign res_valid = out_valid_q;
	assign res_beat  = out_q;

	`JSU_ASSERT_NOW(a_idx_in_group, clk, arst_n, fill_q != 2'd0,
		({1'b0, idx_q} < head.count), "item index beyond head group")
	`JSU_ASSERT_NOW(a_idx_zero_empty, clk, arst_n, fill_q == 2'd0,
		idx_q == 2'd0, "item index not cleared with empty queue")
	`JSU_ASSERT_NOW(a_data_clean, clk, arst_n, res_valid && res_beat.out_valid,
		!res_beat.done_res && res_beat.error_code == ERR_NONE, "data beat carries status")
	`JSU_ASSERT_NOW(a_status_last, clk, arst_n,
		res_valid && (res_beat.done_res || res_beat.error_code != ERR_NONE),
		res_beat.last, "status beat not marked last")
	`JSU_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop,
		fill_q != 2'd0, "queue empty after push")

endmodule
